[hdl/transport_segment_reassembler_macros.svh]
// assertion macros for the transport segment reassembler
`ifndef TRANSPORT_SEGMENT_REASSEMBLER_MACROS_SVH
`define TRANSPORT_SEGMENT_REASSEMBLER_MACROS_SVH
`ifndef SYNTHESIS
`define TSR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsr check failed");
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsr check failed");
`else
`define TSR_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/tsr_pkg.sv]
// shared types and constants for the transport segment reassembler
package tsr_pkg;

  localparam int FRAG_DEPTH_DEF = 2048;
  localparam int SEG_MAX_DEF    = 250;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;
  localparam logic [2:0] ST_READ      = 3'd6;

  typedef enum logic [1:0] {
    ACT_DISCARD,
    ACT_STORE,
    ACT_COMPARE
  } seg_action_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        seg_end;
    logic [10:0] read_index;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] frag_length;
    logic [7:0]  read_data;
  } result_t;

endpackage

[hdl/transport_segment_reassembler.sv]
// transport segment reassembler: fragment store, segment control and result register
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_stall   tsr_pkg::item_t
//   result    out        result_valid / result_stall  tsr_pkg::result_t
//
// one beat per cycle sustained while result_stall is low; the result register loads when stage 1 advances
// stage 0 issues the fragment store read, stage 1 decides and writes back
// the single-port-write store sets the rate: one write and one read each cycle
// reset clears control state only; store contents are never
// read below the fill count before written, so there is no clearing pass
// item_stall rises only when stage 1 holds a beat and the result register is stalled
`include "transport_segment_reassembler_macros.svh"

module transport_segment_reassembler #(
  parameter int FRAG_DEPTH = tsr_pkg::FRAG_DEPTH_DEF,
  parameter int SEG_MAX    = tsr_pkg::SEG_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tsr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tsr_pkg::result_t result
);
  import tsr_pkg::*;

  localparam int AW   = $clog2(FRAG_DEPTH);
  localparam int CW   = $clog2(FRAG_DEPTH + 1);
  localparam int IW   = (CW > 11) ? CW : 11;
  localparam int XW   = ((CW > 8) ? CW : 8) + 1;
  localparam int SMW  = 9;

  // fragment store
  logic [7:0] mem [FRAG_DEPTH];
  logic [7:0] mem_q;

  // control state
  logic          assembling, assembling_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lss, lss_next;
  logic [5:0]    prev_seq, prev_seq_next;
  logic [5:0]    exp_seq, exp_seq_next;
  logic [7:0]    offset, offset_next;
  seg_action_t   action, action_next;
  logic          mismatch, mismatch_next;
  logic          hdr_fin_q, hdr_fin_next;

  // stage 1
  logic       s1_valid;
  item_t      s1_item;
  logic       s1_byp;
  logic [7:0] s1_byp_data;
  logic       s1_adv;
  logic       o_free;
  logic       item_acc;

  logic [7:0]    rd_byte;
  logic [2:0]    st;
  logic [7:0]    rdata;
  logic          store_hit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] lss_fwd;
  logic [7:0]    off_fwd;
  logic [XW-1:0] cmp_idx;
  logic          cmp_miss;
  logic          cmp_any;
  logic          h_fin, h_fir;
  logic [5:0]    h_seq;

  assign o_free     = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && o_free;
  assign item_stall = s1_valid && !o_free;
  assign item_acc   = item_valid && !item_stall;

  assign wr_en   = s1_adv && store_hit;
  assign wr_addr = AW'(count);

  // forward the segment position from stage 1 so back-to-back bytes compare right
  assign lss_fwd = s1_adv ? lss_next : lss;
  assign off_fwd = s1_adv ? offset_next : offset;
  assign rd_addr = (item.operation == OP_READ) ? AW'(item.read_index)
                 : AW'(XW'(lss_fwd) + XW'(off_fwd) - XW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s1_item.data_byte;
    end
    if (item_acc) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // read-during-write to the same entry takes the new byte
  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_item     <= item;
      s1_byp      <= wr_en && (wr_addr == rd_addr);
      s1_byp_data <= s1_item.data_byte;
    end
  end

  assign rd_byte = s1_byp ? s1_byp_data : mem_q;
  assign h_fin   = s1_item.data_byte[7];
  assign h_fir   = s1_item.data_byte[6];
  assign h_seq   = s1_item.data_byte[5:0];
  assign cmp_idx = XW'(lss) + XW'(offset) - XW'(1);
  assign cmp_miss = (cmp_idx >= XW'(count)) || (rd_byte != s1_item.data_byte);
  assign cmp_any  = mismatch || cmp_miss;

  always_comb begin
    assembling_next = assembling;
    count_next      = count;
    lss_next        = lss;
    prev_seq_next   = prev_seq;
    exp_seq_next    = exp_seq;
    offset_next     = offset;
    action_next     = action;
    mismatch_next   = mismatch;
    hdr_fin_next    = hdr_fin_q;
    st              = ST_ACCEPTED;
    rdata           = '0;
    store_hit       = 1'b0;
    if (s1_item.operation == OP_READ) begin
      st = ST_READ;
      if (IW'(s1_item.read_index) < IW'(count)) begin
        rdata = rd_byte;
      end
    end else begin
      if (offset == 8'd0) begin
        hdr_fin_next  = h_fin;
        mismatch_next = 1'b0;
        if (h_fir) begin
          count_next  = '0;
          lss_next    = '0;
          action_next = ACT_STORE;
          if (h_fin) begin
            assembling_next = 1'b0;
          end else begin
            assembling_next = 1'b1;
            prev_seq_next   = h_seq;
            exp_seq_next    = h_seq + 6'd1;
          end
        end else if (!assembling) begin
          action_next = ACT_DISCARD;
          st          = ST_IGNORED;
        end else if (h_seq == prev_seq) begin
          action_next = ACT_COMPARE;
        end else if (h_seq == exp_seq) begin
          action_next = ACT_STORE;
          if (h_fin) begin
            assembling_next = 1'b0;
          end else begin
            prev_seq_next = h_seq;
            exp_seq_next  = h_seq + 6'd1;
            lss_next      = count;
          end
        end else begin
          assembling_next = 1'b0;
          action_next     = ACT_DISCARD;
          st              = ST_ABORTED;
        end
        if (s1_item.seg_end) begin
          if (action_next == ACT_STORE && h_fin) begin
            st = ST_COMPLETE;
          end else if (action_next == ACT_COMPARE) begin
            if (count_next == lss_next) begin
              st = ST_DUPLICATE;
            end else begin
              assembling_next = 1'b0;
              action_next     = ACT_DISCARD;
              st              = ST_ABORTED;
            end
          end
        end
      end else begin
        if (action == ACT_DISCARD) begin
          st = ST_IGNORED;
        end else if (!s1_item.seg_end && ({1'b0, offset} >= SMW'(SEG_MAX - 1))) begin
          // oversize segment
          assembling_next = 1'b0;
          action_next     = ACT_DISCARD;
          st              = ST_ABORTED;
        end else if (action == ACT_STORE) begin
          if (count >= CW'(FRAG_DEPTH)) begin
            assembling_next = 1'b0;
            action_next     = ACT_DISCARD;
            st              = ST_OVERFLOW;
          end else begin
            store_hit  = 1'b1;
            count_next = count + CW'(1);
            st = (s1_item.seg_end && hdr_fin_q) ? ST_COMPLETE : ST_ACCEPTED;
          end
        end else begin
          mismatch_next = cmp_any;
          if (s1_item.seg_end) begin
            if (!cmp_any && (XW'(offset) == XW'(count) - XW'(lss))) begin
              action_next = ACT_DISCARD;
              st          = ST_DUPLICATE;
            end else begin
              assembling_next = 1'b0;
              action_next     = ACT_DISCARD;
              st              = ST_ABORTED;
            end
          end
        end
      end
      if (s1_item.seg_end) begin
        offset_next = 8'd0;
      end else if (offset != 8'hFF) begin
        offset_next = offset + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembling <= 1'b0;
      count      <= '0;
      lss        <= '0;
      prev_seq   <= '0;
      exp_seq    <= '0;
      offset     <= '0;
      action     <= ACT_DISCARD;
      mismatch   <= 1'b0;
      hdr_fin_q  <= 1'b0;
    end else if (s1_adv) begin
      assembling <= assembling_next;
      count      <= count_next;
      lss        <= lss_next;
      prev_seq   <= prev_seq_next;
      exp_seq    <= exp_seq_next;
      offset     <= offset_next;
      action     <= action_next;
      mismatch   <= mismatch_next;
      hdr_fin_q  <= hdr_fin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.status      <= st;
      result.frag_length <= 12'(count_next);
      result.read_data   <= rdata;
    end
  end

  `TSR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(FRAG_DEPTH))
  `TSR_ASSERT_IMP(a_seg_start_bound, clk, rst, 1'b1, lss <= count)
  `TSR_ASSERT_IMP(a_write_store_only, clk, rst, wr_en, (s1_item.operation == OP_PUSH) && (offset != 8'd0) && (action == ACT_STORE))
  `TSR_ASSERT_NEXT(a_stage_to_result, clk, rst, s1_adv, result_valid)
  `TSR_ASSERT_IMP(a_accept_needs_room, clk, rst, item_acc && s1_valid, s1_adv)

endmodule

[tb/tb.sv]
// self-checking testbench for the transport segment reassembler
`timescale 1ns / 1ps

module tb;
  import tsr_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int DEPTH     = FRAG_DEPTH_DEF;
  localparam int SEG_LIMIT = SEG_MAX_DEF;
  localparam int RANDOM_BEATS = 850;
  localparam int HOLD_CYCLES  = 200;

  // tracks reassembly state and queues the reply each beat should produce
  class frag_scoreboard;
    result_t     replies_due[$];
    bit [7:0]    frag_mem [DEPTH];
    bit          assembling;
    int unsigned frag_count;
    int unsigned seg_start;
    int unsigned seg_pos;
    bit [5:0]    prev_seq;
    bit [5:0]    next_seq;
    seg_action_t action;
    bit          mismatch;
    bit          fin_flag;
    int          beats;
    int          checked;
    int          errors;
    int          useful;
    bit [7:0]    seen;

    function new();
      action = ACT_DISCARD;
    endfunction

    function logic [2:0] drop(logic [2:0] code);
      assembling = 1'b0;
      action = ACT_DISCARD;
      return code;
    endfunction

    function logic [2:0] header_status(item_t it);
      logic [5:0] seq;
      logic [2:0] st;
      seq = it.data_byte[5:0];
      st = ST_ACCEPTED;
      fin_flag = it.data_byte[7];
      mismatch = 1'b0;
      if (it.data_byte[6]) begin
        frag_count = 0;
        seg_start = 0;
        action = ACT_STORE;
        if (fin_flag) begin
          assembling = 1'b0;
        end else begin
          assembling = 1'b1;
          prev_seq = seq;
          next_seq = seq + 6'd1;
        end
      end else if (!assembling) begin
        action = ACT_DISCARD;
        st = ST_IGNORED;
      end else if (seq == prev_seq) begin
        action = ACT_COMPARE;
      end else if (seq == next_seq) begin
        action = ACT_STORE;
        if (fin_flag) begin
          assembling = 1'b0;
        end else begin
          prev_seq = seq;
          next_seq = seq + 6'd1;
          seg_start = frag_count;
        end
      end else begin
        st = drop(ST_ABORTED);
      end
      if (it.seg_end) begin
        if (action == ACT_STORE && fin_flag) begin
          st = ST_COMPLETE;
        end else if (action == ACT_COMPARE) begin
          // header-only repeat matches only an empty stored segment
          st = (frag_count == seg_start) ? ST_DUPLICATE : drop(ST_ABORTED);
        end
      end
      return st;
    endfunction

    function logic [2:0] payload_status(item_t it, int unsigned pos);
      int unsigned idx;
      if (action == ACT_DISCARD) return ST_IGNORED;
      if (!it.seg_end && pos >= SEG_LIMIT - 1) return drop(ST_ABORTED);
      if (action == ACT_STORE) begin
        if (frag_count >= DEPTH) return drop(ST_OVERFLOW);
        frag_mem[frag_count] = it.data_byte;
        frag_count++;
        return (it.seg_end && fin_flag) ? ST_COMPLETE : ST_ACCEPTED;
      end
      idx = seg_start + pos - 1;
      if (idx >= frag_count || frag_mem[idx] != it.data_byte) mismatch = 1'b1;
      if (!it.seg_end) return ST_ACCEPTED;
      if (!mismatch && pos == frag_count - seg_start) begin
        action = ACT_DISCARD;
        return ST_DUPLICATE;
      end
      return drop(ST_ABORTED);
    endfunction

    function result_t reassemble(item_t it);
      result_t     r;
      int unsigned pos;
      r.read_data = '0;
      if (it.operation == OP_READ) begin
        r.status = ST_READ;
        if (it.read_index < frag_count && it.read_index < DEPTH)
          r.read_data = frag_mem[it.read_index];
      end else begin
        pos = seg_pos;
        if (pos == 0) r.status = header_status(it);
        else r.status = payload_status(it, pos);
        if (it.seg_end) seg_pos = 0;
        else seg_pos = (pos < 255) ? pos + 1 : 255;
      end
      r.frag_length = frag_count[11:0];
      return r;
    endfunction

    function void note_beat(item_t it);
      result_t r;
      r = reassemble(it);
      beats++;
      seen[r.status] = 1'b1;
      if (r.status != ST_IGNORED) useful++;
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected result beat: status %0d", got.status);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.frag_length !== want.frag_length) begin
        $error("frag_length: expected %0d, actual %0d", want.frag_length, got.frag_length);
        errors++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected 0x%02h, actual 0x%02h", want.read_data, got.read_data);
        errors++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  frag_scoreboard sb = new();

  int burst_left = 0;
  bit gaps_on = 1'b1;
  int rx_mode = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int rx_tick = 0;

  transport_segment_reassembler DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always #2 clk = ~clk;

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 9) < 6);
        default: result_stall <= ((rx_tick % 8) < 3);
      endcase
    end
    rx_tick++;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_reply(result);
  end

  // entered and left at a falling edge
  task automatic send_item(input item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_beat(it);
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input bit last);
    item_t it;
    it.operation = OP_PUSH;
    it.data_byte = b;
    it.seg_end = last;
    it.read_index = 11'($urandom);
    send_item(it);
  endtask

  task automatic read_byte(input int idx);
    item_t it;
    it.operation = OP_READ;
    it.data_byte = 8'($urandom);
    it.seg_end = 1'($urandom);
    it.read_index = 11'(idx);
    send_item(it);
  endtask

  task automatic send_segment(input logic [7:0] hdr, input byte_q_t pl);
    push_byte(hdr, pl.size() == 0);
    for (int i = 0; i < pl.size(); i++) push_byte(pl[i], i == pl.size() - 1);
  endtask

  task automatic wait_replies();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic byte_q_t rand_bytes(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.insert(q.size(), 8'($urandom));
    return q;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    if (r < 99) return $urandom_range(41, SEG_LIMIT - 1);
    return $urandom_range(SEG_LIMIT, SEG_LIMIT + 20);  // oversize
  endfunction

  function automatic int pick_index();
    if ($urandom_range(0, 9) < 7 && sb.frag_count > 0)
      return $urandom_range(0, sb.frag_count - 1);
    return $urandom_range(0, DEPTH - 1);
  endfunction

  task automatic random_fragment();
    int         nseg;
    int         k;
    bit         fin;
    logic [5:0] seq;
    logic [5:0] s;
    byte_q_t    pl;
    byte_q_t    alt;
    // stray continuation, usually dropped while idle
    if ($urandom_range(0, 9) == 0)
      send_segment({1'($urandom), 1'b0, 6'($urandom)}, rand_bytes($urandom_range(0, 4)));
    nseg = $urandom_range(1, 6);
    seq = 6'($urandom);
    for (int i = 0; i < nseg; i++) begin
      fin = (i == nseg - 1);
      pl = rand_bytes(pick_len());
      send_segment({fin, i == 0, seq}, pl);
      while ($urandom_range(0, 3) == 0) read_byte(pick_index());
      if (!fin) begin
        case ($urandom_range(0, 11))
          0: send_segment({1'($urandom), 1'b0, seq}, pl);
          1: begin
            // repeat that differs from the stored segment
            alt = pl;
            k = $urandom_range(0, 2);
            if (k == 0 && alt.size() > 0)
              alt[$urandom_range(0, alt.size() - 1)] ^= 8'($urandom_range(1, 255));
            else if (k == 2 && alt.size() > 0)
              void'(alt.pop_back());
            else
              alt.insert(alt.size(), 8'($urandom));
            send_segment({1'b0, 1'b0, seq}, alt);
            return;
          end
          2: begin
            s = seq + 6'($urandom_range(2, 62));
            send_segment({1'($urandom), 1'b0, s}, rand_bytes($urandom_range(0, 6)));
            return;
          end
          3: return;
          default: ;
        endcase
      end
      seq = seq + 6'd1;
    end
  endtask

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rx_mode = 1;
    read_byte(0);
    read_byte(DEPTH - 1);
    push_byte(8'h3F, 1'b0);   // continuation while idle
    push_byte(8'hFF, 1'b1);
    push_byte(8'hC0, 1'b0);   // single-segment fragment
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h7F, 1'b0);   // seq wraps from 63 to 0
    push_byte(8'hA5, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'h00, 1'b0);   // identical repeat
    push_byte(8'h5A, 1'b1);
    push_byte(8'h00, 1'b0);   // repeat with a changed byte
    push_byte(8'h5B, 1'b1);
    push_byte(8'h40, 1'b1);   // header-only segments
    push_byte(8'h01, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h05, 1'b1);   // out-of-order seq
    push_byte(8'h41, 1'b0);
    push_byte(8'h11, 1'b1);
    push_byte(8'h82, 1'b1);
    read_byte(0);
    read_byte(1);
    wait_replies();

    // receiver holds off while the sender keeps pushing
    gaps_on = 1'b0;
    rx_mode = 1;
    hold_req = 1'b1;
    while (sb.beats < RANDOM_BEATS) begin
      random_fragment();
      if ($urandom_range(0, 7) == 0) begin
        rx_mode = $urandom_range(0, 3);
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 29) == 0) wait_replies();
    end
    wait_replies();
    repeat (10) @(negedge clk);

    $display("tb: %0d beats sent, %0d results checked, %0d mismatches",
             sb.beats, sb.checked, sb.errors);
    $display("tb: status codes seen (bit per code) %b over directed and random fragments",
             sb.seen);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tsr_pkg.sv
hdl/transport_segment_reassembler.sv
tb/tb.sv
